>>> hdl/maoc_pkg.sv
// ----------------------------------------------------------------------------
// maoc_pkg
// Shared types and constants for the moving average / offset / clamp unit.
// ----------------------------------------------------------------------------
package maoc_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned PotW    = 10;
  localparam int unsigned OutW    = 12;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned WinW    = 5;
  localparam int unsigned EntryW  = 3 * SampleW + PotW;

  localparam logic [2:0] RegWindow   = 3'd0;
  localparam logic [2:0] RegOffsetX  = 3'd1;
  localparam logic [2:0] RegOffsetY  = 3'd2;
  localparam logic [2:0] RegOffsetZ  = 3'd3;
  localparam logic [2:0] RegPotLimit = 3'd4;

  localparam logic [WinW-1:0] WindowReset   = 5'd6;
  localparam logic [CfgW-1:0] PotLimitReset = 11'd1024;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic signed [SampleW-1:0] sample_z;
    logic        [PotW-1:0]    sample_pot;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_x;
    logic signed [OutW-1:0] out_y;
    logic signed [OutW-1:0] out_z;
    logic        [PotW-1:0] out_pot;
  } out_item_t;

endpackage

>>> hdl/maoc_lane.sv
// ----------------------------------------------------------------------------
// maoc_lane
// One channel accumulator: sums history entries, then divides the sum by the
// window, one quotient bit per div_step_i cycle (truncating toward zero).
// ----------------------------------------------------------------------------
module maoc_lane #(
  parameter int unsigned InW  = 8,
  parameter int unsigned SumW = 12,
  parameter int unsigned WW   = 5
) (
  input  logic                   clk_i,
  input  logic                   clr_i,
  input  logic                   acc_i,
  input  logic signed [InW-1:0]  val_i,
  input  logic                   div_start_i,
  input  logic                   div_step_i,
  input  logic [WW-1:0]          win_i,
  output logic signed [SumW-1:0] quot_o
);

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] mag_q, mag_d, rem_q, rem_d;
  logic            neg_q, neg_d;
  logic [SumW:0]   trial;

  assign trial = {rem_q, mag_q[SumW-1]} - {{(SumW+1-WW){1'b0}}, win_i};

  always_comb begin
    sum_d = sum_q;
    mag_d = mag_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (clr_i) begin
      sum_d = '0;
    end else if (acc_i) begin
      sum_d = sum_q + SumW'(val_i);
    end
    if (div_start_i) begin
      neg_d = sum_q[SumW-1];
      mag_d = sum_q[SumW-1] ? SumW'(-sum_q) : sum_q;
      rem_d = '0;
    end else if (div_step_i) begin
      if (!trial[SumW]) begin
        rem_d = trial[SumW-1:0];
        mag_d = {mag_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumW-2:0], mag_q[SumW-1]};
        mag_d = {mag_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quot_o = neg_q ? SumW'(-mag_q) : mag_q;

endmodule

>>> hdl/maoc_merge.sv
// ----------------------------------------------------------------------------
// maoc_merge
// Combines lane quotients or bypass samples: adds axis offsets, clamps pot.
// ----------------------------------------------------------------------------
module maoc_merge #(
  parameter int unsigned SumW = 12,
  parameter int unsigned PSumW = 14
) (
  input  logic                          bypass_i,
  input  maoc_pkg::in_item_t            smp_i,
  input  logic signed [SumW-1:0]        qx_i,
  input  logic signed [SumW-1:0]        qy_i,
  input  logic signed [SumW-1:0]        qz_i,
  input  logic signed [PSumW-1:0]       qp_i,
  input  logic signed [maoc_pkg::CfgW-1:0] off_x_i,
  input  logic signed [maoc_pkg::CfgW-1:0] off_y_i,
  input  logic signed [maoc_pkg::CfgW-1:0] off_z_i,
  input  logic [maoc_pkg::CfgW-1:0]     pot_limit_i,
  output maoc_pkg::out_item_t           res_o
);

  logic signed [maoc_pkg::OutW-1:0] ax, ay, az;
  logic [PSumW-1:0] ap;

  always_comb begin
    if (bypass_i) begin
      ax = maoc_pkg::OutW'(smp_i.sample_x);
      ay = maoc_pkg::OutW'(smp_i.sample_y);
      az = maoc_pkg::OutW'(smp_i.sample_z);
      ap = PSumW'(smp_i.sample_pot);
    end else begin
      ax = maoc_pkg::OutW'(qx_i);
      ay = maoc_pkg::OutW'(qy_i);
      az = maoc_pkg::OutW'(qz_i);
      ap = PSumW'(qp_i);
    end
    res_o.out_x = ax + maoc_pkg::OutW'(off_x_i);
    res_o.out_y = ay + maoc_pkg::OutW'(off_y_i);
    res_o.out_z = az + maoc_pkg::OutW'(off_z_i);
    // averaged pot is never negative
    if (ap > PSumW'(pot_limit_i)) begin
      res_o.out_pot = pot_limit_i[maoc_pkg::PotW-1:0];
    end else begin
      res_o.out_pot = ap[maoc_pkg::PotW-1:0];
    end
  end

endmodule

>>> hdl/moving_average_offset_clamp_unit.sv
// ----------------------------------------------------------------------------
// moving_average_offset_clamp_unit
// Windowed moving average of three axes and a pot value, plus offsets/clamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_stall_o/in_item_i carry one sample request; out_valid_o/
//   out_stall_i/out_item_o carry one result per sample. cfg_valid_i/
//   cfg_ready_o/cfg_index_i/cfg_data_i write registers; the user must write
//   them only while idle, as the block itself does not enforce it.
// Flow (W = window clipped to HISTORY_DEPTH, P = history entries padded):
//   W <= 1: the sample passes through StOut into the output register.
//   W > 1 : pad writes one history entry per cycle (P of them, P up to W),
//   StFill then drops the oldest entry and appends the sample, W entries
//   sum through the single history read port, then bit-serial division in
//   four lanes. The history read port and the serial divider set latency.
// Reset: window 6, offsets 0, pot limit 1024, history empty; no clearing pass.
// Stall: a finished result waits in the output register; the next sample is
//   not taken until that result is delivered, at the earliest the cycle after.
// ----------------------------------------------------------------------------
module moving_average_offset_clamp_unit #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  maoc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output maoc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [maoc_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned WW    = (CW > maoc_pkg::WinW) ? CW : maoc_pkg::WinW;
  localparam int unsigned SumW  = maoc_pkg::SampleW + CW + 1;
  localparam int unsigned PSumW = maoc_pkg::PotW + CW + 1;
  localparam int unsigned DivCW = $clog2(PSumW + 1);
  localparam int unsigned EW    = maoc_pkg::EntryW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFill = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [maoc_pkg::WinW-1:0] win_reg_q;
  logic signed [maoc_pkg::CfgW-1:0] off_x_q, off_y_q, off_z_q;
  logic [maoc_pkg::CfgW-1:0] pot_limit_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [DivCW-1:0] dcnt_q, dcnt_d;
  logic [CW-1:0] w_q, w_d;
  logic bypass_q, bypass_d;
  maoc_pkg::in_item_t smp_q, smp_d;

  logic [EW-1:0] hist_mem [HISTORY_DEPTH];
  logic [EW-1:0] rd_q;
  logic          rd_vld_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic          out_valid_q;
  maoc_pkg::out_item_t out_q;
  maoc_pkg::out_item_t res;

  logic [WW-1:0] win_ext;
  logic [CW-1:0] w_eff;
  logic accept;
  logic lane_clr, lane_acc, div_start, div_step;
  logic signed [SumW-1:0] qx, qy, qz;
  logic signed [PSumW-1:0] qp;
  maoc_pkg::in_item_t rd_item;

  // base < depth and off <= depth, so one conditional subtract wraps the ring
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return AW'(s);
  endfunction

  assign win_ext = WW'(win_reg_q);
  always_comb begin
    if (win_ext > WW'(HISTORY_DEPTH)) begin
      w_eff = CW'(HISTORY_DEPTH);
    end else begin
      w_eff = CW'(win_ext);
    end
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign rd_item     = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_reg_q   <= maoc_pkg::WindowReset;
      off_x_q     <= '0;
      off_y_q     <= '0;
      off_z_q     <= '0;
      pot_limit_q <= maoc_pkg::PotLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        maoc_pkg::RegWindow:   win_reg_q   <= cfg_data_i[maoc_pkg::WinW-1:0];
        maoc_pkg::RegOffsetX:  off_x_q     <= cfg_data_i;
        maoc_pkg::RegOffsetY:  off_y_q     <= cfg_data_i;
        maoc_pkg::RegOffsetZ:  off_z_q     <= cfg_data_i;
        maoc_pkg::RegPotLimit: pot_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    oldest_d  = oldest_q;
    idx_d     = idx_q;
    dcnt_d    = dcnt_q;
    w_d       = w_q;
    bypass_d  = bypass_q;
    smp_d     = smp_q;
    wr_en     = 1'b0;
    wr_addr   = slot(oldest_q, count_q);
    rd_addr   = slot(oldest_q, idx_q);
    lane_clr  = 1'b0;
    lane_acc  = 1'b0;
    div_start = 1'b0;
    div_step  = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          smp_d    = in_item_i;
          w_d      = w_eff;
          bypass_d = (w_eff <= CW'(1));
          if (w_eff <= CW'(1)) begin
            state_d = StOut;
          end else begin
            // trim to window now; padding follows one entry per cycle
            if (count_q > w_eff) begin
              oldest_d = slot(oldest_q, count_q - w_eff);
              count_d  = w_eff;
            end
            state_d = StFill;
          end
        end
      end
      StFill: begin
        if (count_q < w_q) begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end else begin
          // drop oldest, append current sample at the new tail
          wr_en    = 1'b1;
          wr_addr  = slot(oldest_q, w_q);
          oldest_d = slot(oldest_q, CW'(1));
          idx_d    = '0;
          lane_clr = 1'b1;
          state_d  = StSum;
        end
      end
      StSum: begin
        lane_acc = rd_vld_q;
        if (idx_q < w_q) begin
          idx_d = idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d   = StDiv;
          div_start = 1'b1;
          dcnt_d    = '0;
        end
      end
      StDiv: begin
        div_step = 1'b1;
        dcnt_d   = dcnt_q + DivCW'(1);
        if (dcnt_q == DivCW'(PSumW - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      oldest_q    <= '0;
      idx_q       <= '0;
      dcnt_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      bypass_q    <= 1'b1;
      w_q         <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      idx_q    <= idx_d;
      dcnt_q   <= dcnt_d;
      bypass_q <= bypass_d;
      w_q      <= w_d;
      rd_vld_q <= (state_q == StSum) && (idx_q < w_q);
      if (state_q == StOut) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    if (wr_en) begin
      hist_mem[wr_addr] <= smp_q;
    end
    rd_q <= hist_mem[rd_addr];
    if (state_q == StOut) begin
      out_q <= res;
    end
  end

  maoc_lane #(.InW(maoc_pkg::SampleW), .SumW(SumW), .WW(CW)) u_lane_x (
    .clk_i, .clr_i(lane_clr), .acc_i(lane_acc), .val_i(rd_item.sample_x),
    .div_start_i(div_start), .div_step_i(div_step && dcnt_q < DivCW'(SumW)),
    .win_i(w_q), .quot_o(qx)
  );
  maoc_lane #(.InW(maoc_pkg::SampleW), .SumW(SumW), .WW(CW)) u_lane_y (
    .clk_i, .clr_i(lane_clr), .acc_i(lane_acc), .val_i(rd_item.sample_y),
    .div_start_i(div_start), .div_step_i(div_step && dcnt_q < DivCW'(SumW)),
    .win_i(w_q), .quot_o(qy)
  );
  maoc_lane #(.InW(maoc_pkg::SampleW), .SumW(SumW), .WW(CW)) u_lane_z (
    .clk_i, .clr_i(lane_clr), .acc_i(lane_acc), .val_i(rd_item.sample_z),
    .div_start_i(div_start), .div_step_i(div_step && dcnt_q < DivCW'(SumW)),
    .win_i(w_q), .quot_o(qz)
  );
  maoc_lane #(.InW(maoc_pkg::PotW + 1), .SumW(PSumW), .WW(CW)) u_lane_p (
    .clk_i, .clr_i(lane_clr), .acc_i(lane_acc),
    .val_i({1'b0, rd_item.sample_pot}),
    .div_start_i(div_start), .div_step_i(div_step),
    .win_i(w_q), .quot_o(qp)
  );

  maoc_merge #(.SumW(SumW), .PSumW(PSumW)) u_merge (
    .bypass_i(bypass_q), .smp_i(smp_q),
    .qx_i(qx), .qy_i(qy), .qz_i(qz), .qp_i(qp),
    .off_x_i(off_x_q), .off_y_i(off_y_q), .off_z_i(off_z_q),
    .pot_limit_i(pot_limit_q), .res_o(res)
  );

endmodule
